// ===== design/mts_pkg.sv =====
// mts_pkg: shared types, constants and tag tables for the markup tag stripper
// depends on nothing; imported by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

  localparam int CHAR_BITS       = 16;
  localparam int LOOKAHEAD_DEPTH = 8;
  localparam int COUNT_W         = $clog2(LOOKAHEAD_DEPTH + 1);
  localparam int TAG_COUNT       = 8;
  localparam int TAG_MAXLEN      = 8;
  localparam int TAG_IDX_W       = $clog2(TAG_MAXLEN);

  typedef logic [CHAR_BITS-1:0] char_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [TAG_COUNT-1:0] tag_mask_t;

  localparam char_t CH_LBRACKET = CHAR_BITS'(8'h5b);
  localparam char_t CH_RBRACKET = CHAR_BITS'(8'h5d);
  localparam char_t CH_UPPER_A  = CHAR_BITS'(8'h41);
  localparam char_t CH_UPPER_Z  = CHAR_BITS'(8'h5a);
  localparam char_t CASE_OFFSET = CHAR_BITS'(8'h20);

  // match result codes
  localparam logic [1:0] MATCH_NONE   = 2'd0;
  localparam logic [1:0] MATCH_PREFIX = 2'd1;
  localparam logic [1:0] MATCH_CLOSED = 2'd2;
  localparam logic [1:0] MATCH_OPENER = 2'd3;

  // lower-case tag text, unused positions zero
  localparam logic [7:0] TAG_TEXT [TAG_COUNT][TAG_MAXLEN] = '{
    '{8'h5b, 8'h62, 8'h5d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // [b]
    '{8'h5b, 8'h69, 8'h5d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // [i]
    '{8'h5b, 8'h2f, 8'h62, 8'h5d, 8'h00, 8'h00, 8'h00, 8'h00},  // [/b]
    '{8'h5b, 8'h2f, 8'h69, 8'h5d, 8'h00, 8'h00, 8'h00, 8'h00},  // [/i]
    '{8'h5b, 8'h63, 8'h6f, 8'h6c, 8'h6f, 8'h72, 8'h00, 8'h00},  // [color
    '{8'h5b, 8'h2f, 8'h63, 8'h6f, 8'h6c, 8'h6f, 8'h72, 8'h5d},  // [/color]
    '{8'h5b, 8'h73, 8'h69, 8'h7a, 8'h65, 8'h00, 8'h00, 8'h00},  // [size
    '{8'h5b, 8'h2f, 8'h73, 8'h69, 8'h7a, 8'h65, 8'h5d, 8'h00}   // [/size]
  };

  localparam count_t TAG_LEN [TAG_COUNT] = '{
    COUNT_W'(3), COUNT_W'(3), COUNT_W'(4), COUNT_W'(4),
    COUNT_W'(6), COUNT_W'(8), COUNT_W'(5), COUNT_W'(7)
  };

  localparam tag_mask_t TAG_OPENER = TAG_COUNT'(8'b0101_0000);

  // controls for one lookahead cell
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  function automatic char_t fold_case(input char_t c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return char_t'(c + CASE_OFFSET);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/mts_in_if.sv =====
// mts_in_if: input character channel of the markup tag stripper
// depends on mts_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mts_in_if import mts_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t in_char;
  logic  in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

`default_nettype wire

// ===== design/mts_out_if.sv =====
// mts_out_if: result channel of the markup tag stripper
// depends on mts_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mts_out_if import mts_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t out_char;
  logic  char_valid;
  logic  out_last;

  modport source (output valid, output out_char, output char_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_char, input char_valid, input out_last,
                  output ready);
endinterface

`default_nettype wire

// ===== design/mts_cell.sv =====
// mts_cell: one lookahead cell, holds a character and passes it to its neighbor
// depends on mts_pkg
`timescale 1ns / 1ps
`default_nettype none

module mts_cell import mts_pkg::*; (
  input  wire       clk,
  input  cell_ctl_t ctl,
  input  char_t     load_data,
  input  char_t     from_next,
  output char_t     data
);

  char_t held;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      held <= load_data;
    end else if (ctl.shift) begin
      held <= from_next;
    end
  end

  assign data = held;

endmodule

`default_nettype wire

// ===== design/mts_match.sv =====
// mts_match: extends the running tag match by one character
// depends on mts_pkg
`timescale 1ns / 1ps
`default_nettype none

module mts_match import mts_pkg::*; (
  input  tag_mask_t  alive,
  input  count_t     pos,
  input  char_t      c,
  output logic [1:0] result,
  output tag_mask_t  alive_next
);

  char_t     folded;
  tag_mask_t hit;
  tag_mask_t done;
  count_t    pos_inc;

  assign folded  = fold_case(c);
  assign pos_inc = count_t'(pos + 1'b1);

  always_comb begin
    for (int k = 0; k < TAG_COUNT; k++) begin
      hit[k]  = alive[k] && (pos < TAG_LEN[k]) &&
                (folded == CHAR_BITS'(TAG_TEXT[k][pos[TAG_IDX_W-1:0]]));
      done[k] = hit[k] && (TAG_LEN[k] == pos_inc);
    end
  end

  always_comb begin
    if (hit == '0) begin
      result = MATCH_NONE;
    end else if ((done & TAG_OPENER) != '0) begin
      result = MATCH_OPENER;
    end else if (done != '0) begin
      result = MATCH_CLOSED;
    end else begin
      result = MATCH_PREFIX;
    end
  end

  assign alive_next = hit;

endmodule

`default_nettype wire

// ===== design/markup_tag_stripper_core.sv =====
// markup_tag_stripper_core: top level of the markup tag stripper
// depends on mts_pkg, mts_in_if, mts_out_if, mts_cell, mts_match
//
// channel    dir  payload                          handshake
// in_chan    in   in_char, in_last                 valid / ready
// out_chan   out  out_char, char_valid, out_last   valid / ready
// cfg        in   cfg_wdata (strip_enable)         cfg_we, no wait
//
// one character per cycle while no held text must be flushed and the output
// is not stalled; a failed match or a disable with characters held
// checks the character, drains the held ones through cell 0, then takes
// the request itself; a last character leaving characters held is taken,
// then the held ones drain and the end marker follows after that
// rst is synchronous: clears count, skip mode and all valids, enable to 1
// out_chan.ready low with a result held freezes output register and drain
`timescale 1ns / 1ps
`default_nettype none

module markup_tag_stripper_core import mts_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire        cfg_wdata,
  mts_in_if.sink     in_chan,
  mts_out_if.source  out_chan
);

  logic      strip_enable;
  count_t    count;
  logic      skip;
  tag_mask_t alive;
  logic      drain;
  logic      eom_pend;
  logic      p_valid;
  char_t     p_char;
  logic      p_last;
  logic      o_valid;
  char_t     o_char;
  logic      o_cv;
  logic      o_last;

  count_t    count_next;
  logic      skip_next;
  tag_mask_t alive_next;
  logic      drain_next;
  logic      eom_pend_next;

  logic       slot_free;
  logic       act_drain;
  logic       act_eom;
  logic       act_item;
  logic       consumed;
  logic       emit_char;
  logic       load_cell;
  logic       is_lb;
  logic       is_rb;
  logic [1:0] m_result;
  tag_mask_t  m_alive;
  count_t     count_step;

  char_t     cell_data [LOOKAHEAD_DEPTH];
  cell_ctl_t cell_ctl  [LOOKAHEAD_DEPTH];

  mts_match u_match (
    .alive      (alive),
    .pos        (count),
    .c          (p_char),
    .result     (m_result),
    .alive_next (m_alive)
  );

  for (genvar i = 0; i < LOOKAHEAD_DEPTH; i++) begin : g_cell
    char_t nb;
    if (i == LOOKAHEAD_DEPTH - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_data[i+1];
    end
    assign cell_ctl[i].shift = act_drain;
    assign cell_ctl[i].load  = load_cell && (count == COUNT_W'(i));
    mts_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .load_data (p_char),
      .from_next (nb),
      .data      (cell_data[i])
    );
  end

  assign slot_free = !o_valid || out_chan.ready;
  assign act_drain = slot_free && drain;
  assign act_eom   = slot_free && !drain && eom_pend;
  assign act_item  = slot_free && !drain && !eom_pend && p_valid;
  assign is_lb     = (p_char == CH_LBRACKET);
  assign is_rb     = (p_char == CH_RBRACKET);

  always_comb begin
    count_step    = count;
    skip_next     = skip;
    alive_next    = alive;
    drain_next    = drain;
    eom_pend_next = eom_pend;
    consumed      = 1'b0;
    emit_char     = 1'b0;
    load_cell     = 1'b0;
    if (act_drain) begin
      count_step = count_t'(count - 1'b1);
      drain_next = (count_step != '0);
    end else if (act_eom) begin
      eom_pend_next = 1'b0;
    end else if (act_item) begin
      if (!strip_enable) begin
        skip_next = 1'b0;
        if (count != '0) begin
          drain_next = 1'b1;
        end else begin
          emit_char = 1'b1;
          consumed  = 1'b1;
        end
      end else if (skip) begin
        consumed = 1'b1;
        if (is_rb) begin
          skip_next = 1'b0;
        end
      end else if (count == '0) begin
        consumed = 1'b1;
        if (is_lb) begin
          load_cell  = 1'b1;
          count_step = count_t'(1);
          alive_next = '1;
        end else begin
          emit_char = 1'b1;
        end
      end else begin
        case (m_result)
          MATCH_NONE: begin
            drain_next = 1'b1;
          end
          MATCH_PREFIX: begin
            consumed   = 1'b1;
            load_cell  = 1'b1;
            count_step = count_t'(count + 1'b1);
            alive_next = m_alive;
          end
          MATCH_CLOSED: begin
            consumed   = 1'b1;
            count_step = '0;
          end
          MATCH_OPENER: begin
            consumed   = 1'b1;
            count_step = '0;
            skip_next  = 1'b1;
          end
          default: begin
            drain_next = 1'b1;
          end
        endcase
      end
      // end of string: flush what is held, then the end marker
      if (consumed && p_last) begin
        skip_next     = 1'b0;
        drain_next    = (count_step != '0);
        eom_pend_next = 1'b1;
      end
    end
    count_next = count_step;
  end

  assign in_chan.ready = !p_valid || (act_item && consumed);

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_enable <= 1'b1;
      count        <= '0;
      skip         <= 1'b0;
      alive        <= '0;
      drain        <= 1'b0;
      eom_pend     <= 1'b0;
      p_valid      <= 1'b0;
      o_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        strip_enable <= cfg_wdata;
      end
      count    <= count_next;
      skip     <= skip_next;
      alive    <= alive_next;
      drain    <= drain_next;
      eom_pend <= eom_pend_next;
      if (in_chan.valid && in_chan.ready) begin
        p_valid <= 1'b1;
      end else if (act_item && consumed) begin
        p_valid <= 1'b0;
      end
      if (act_drain || act_eom || emit_char) begin
        o_valid <= 1'b1;
      end else if (out_chan.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      p_char <= in_chan.in_char;
      p_last <= in_chan.in_last;
    end
    if (act_drain) begin
      o_char <= cell_data[0];
      o_cv   <= 1'b1;
      o_last <= 1'b0;
    end else if (act_eom) begin
      o_char <= '0;
      o_cv   <= 1'b0;
      o_last <= 1'b1;
    end else if (emit_char) begin
      o_char <= p_char;
      o_cv   <= 1'b1;
      o_last <= 1'b0;
    end
  end

  assign out_chan.valid      = o_valid;
  assign out_chan.out_char   = o_char;
  assign out_chan.char_valid = o_cv;
  assign out_chan.out_last   = o_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count < COUNT_W'(LOOKAHEAD_DEPTH))
    else $error("lookahead count out of range");

  a_skip_empty: assert property (@(posedge clk) disable iff (rst)
    skip |-> (count == '0))
    else $error("skip mode with held characters");

  a_drain_held: assert property (@(posedge clk) disable iff (rst)
    drain |-> (count != '0))
    else $error("drain with empty lookahead");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (out_chan.valid && !out_chan.char_valid) |-> (out_chan.out_last && out_chan.out_char == '0))
    else $error("end marker malformed");

endmodule

`default_nettype wire

// ===== sim/markup_tag_stripper_core_tb.sv =====
// markup_tag_stripper_core_tb: directed and random tests of tag stripping on character streams
// depends on mts_pkg, mts_in_if, mts_out_if and markup_tag_stripper_core
// results are checked in order against a text predictor kept inside the bench
`timescale 1ns / 1ps

module markup_tag_stripper_core_tb;
  import mts_pkg::*;

  localparam char_t PRINT_LO = char_t'(8'h20);
  localparam char_t PRINT_HI = char_t'(8'h7e);

  typedef struct packed {
    char_t ch;
    logic  kept;
    logic  ends;
  } text_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  mts_in_if  in_chan ();
  mts_out_if out_chan ();

  markup_tag_stripper_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  string tag_forms [8] = '{"[b]", "[i]", "[/b]", "[/i]", "[color", "[/color]", "[size",
                           "[/size]"};
  bit    tag_opens [8] = '{0, 0, 0, 0, 1, 0, 1, 0};

  text_result_t expected_text [$];
  char_t        held_text [LOOKAHEAD_DEPTH];
  int           held_count;
  bit           skip_mode;
  bit           strip_on;
  int           mismatch_count = 0;
  int           counted_chars;
  int           gap_pct = 0;
  int           stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("markup_tag_stripper_core: mismatch");
    $finish;
  end

  // text predictor
  function automatic char_t lower_ascii(input char_t c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic void emit(input char_t c, input logic kept, input logic ends);
    expected_text.push_back('{c, kept, ends});
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < held_count; i++) begin
      emit(held_text[i], 1'b1, 1'b0);
    end
    held_count = 0;
  endfunction

  function automatic void take_fresh(input char_t c);
    if (c == CH_LBRACKET) begin
      held_text[0] = c;
      held_count = 1;
    end else begin
      emit(c, 1'b1, 1'b0);
    end
  endfunction

  function automatic logic [1:0] tag_progress(input char_t c);
    int n;
    bit ok;
    n = held_count;
    for (int k = 0; k < 8; k++) begin
      if (tag_forms[k].len() <= n) continue;
      ok = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (lower_ascii(held_text[i]) != char_t'(tag_forms[k][i])) ok = 1'b0;
      end
      if (!ok || lower_ascii(c) != char_t'(tag_forms[k][n])) continue;
      if (tag_forms[k].len() == n + 1) begin
        return tag_opens[k] ? MATCH_OPENER : MATCH_CLOSED;
      end
      return MATCH_PREFIX;
    end
    return MATCH_NONE;
  endfunction

  function automatic void predict_char(input char_t c, input logic lst);
    logic [1:0] progress;
    if (!strip_on) begin
      flush_held();
      skip_mode = 1'b0;
      emit(c, 1'b1, 1'b0);
    end else if (skip_mode) begin
      if (c == CH_RBRACKET) skip_mode = 1'b0;
    end else if (held_count == 0) begin
      take_fresh(c);
    end else begin
      progress = tag_progress(c);
      if (progress == MATCH_NONE) begin
        flush_held();
        take_fresh(c);
      end else if (progress == MATCH_PREFIX) begin
        if (held_count < LOOKAHEAD_DEPTH) begin
          held_text[held_count] = c;
          held_count++;
        end
      end else begin
        held_count = 0;
        if (progress == MATCH_OPENER) skip_mode = 1'b1;
      end
    end
    if (lst) begin
      flush_held();
      skip_mode = 1'b0;
      emit('0, 1'b0, 1'b1);
    end
  endfunction

  // request side
  task automatic send_char(input char_t c, input logic lst);
    if ($urandom_range(99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_chan.valid   <= 1'b1;
    in_chan.in_char <= c;
    in_chan.in_last <= lst;
    do @(posedge clk); while (!in_chan.ready);
    if (!(strip_on && skip_mode)) counted_chars++;
    predict_char(c, lst);
  endtask

  task automatic send_text(input string s, input bit end_string);
    for (int i = 0; i < s.len(); i++) begin
      send_char(char_t'(s[i]), end_string && i == s.len() - 1);
    end
  endtask

  task automatic quiesce();
    in_chan.valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_strip(input bit en);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
    strip_on = en;
  endtask

  function automatic char_t mixed_case(input byte ch);
    char_t c;
    c = char_t'(ch);
    if (c >= CH_UPPER_A + CASE_OFFSET && c <= CH_UPPER_Z + CASE_OFFSET && $urandom_range(1))
      c = c - CASE_OFFSET;
    return c;
  endfunction

  task automatic send_random_piece();
    char_t piece [$];
    char_t c;
    int    pick;
    int    k;
    int    cut;
    pick = $urandom_range(99);
    k = $urandom_range(7);
    if (pick < 35) begin
      for (int i = 0; i < tag_forms[k].len(); i++) piece.push_back(mixed_case(tag_forms[k][i]));
      if (tag_opens[k]) begin
        repeat ($urandom_range(5)) begin
          c = char_t'($urandom_range(PRINT_HI, PRINT_LO));
          piece.push_back(c == CH_RBRACKET ? CH_LBRACKET : c);
        end
        if ($urandom_range(9) != 0) piece.push_back(CH_RBRACKET);
      end
    end else if (pick < 50) begin
      // broken tag
      cut = $urandom_range(tag_forms[k].len() - 1, 1);
      for (int i = 0; i < cut; i++) piece.push_back(mixed_case(tag_forms[k][i]));
      piece.push_back($urandom_range(1) ? CH_LBRACKET : char_t'($urandom_range(PRINT_HI, PRINT_LO)));
    end else if (pick < 85) begin
      repeat ($urandom_range(6, 1)) piece.push_back(char_t'($urandom_range(PRINT_HI, PRINT_LO)));
    end else begin
      repeat ($urandom_range(3, 1)) piece.push_back(char_t'($urandom));
    end
    foreach (piece[i]) begin
      send_char(piece[i], (i == piece.size() - 1 && $urandom_range(3) == 0) ||
                          $urandom_range(59) == 0);
    end
  endtask

  // result side
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    text_result_t want;
    if (!rst && out_chan.valid && out_chan.ready) begin
      if (expected_text.size() == 0) begin
        $display("%0t unexpected result: out_char %h char_valid %b out_last %b", $time,
                 out_chan.out_char, out_chan.char_valid, out_chan.out_last);
        mismatch_count++;
      end else begin
        want = expected_text.pop_front();
        if (out_chan.out_char !== want.ch) begin
          $display("%0t out_char expected %h actual %h", $time, want.ch, out_chan.out_char);
          mismatch_count++;
        end
        if (out_chan.char_valid !== want.kept) begin
          $display("%0t char_valid expected %b actual %b", $time, want.kept,
                   out_chan.char_valid);
          mismatch_count++;
        end
        if (out_chan.out_last !== want.ends) begin
          $display("%0t out_last expected %b actual %b", $time, want.ends, out_chan.out_last);
          mismatch_count++;
        end
      end
    end
  end

  // tests
  task automatic test_extremes();
    send_char('0, 1'b0);
    send_char('1, 1'b1);
    quiesce();
  endtask

  task automatic test_rescan_and_wide();
    send_text("[[B]", 1'b1);
    send_char(CH_LBRACKET, 1'b0);
    send_char(CH_LBRACKET | char_t'(16'h0100), 1'b1);
    quiesce();
  endtask

  task automatic test_unclosed_opener();
    send_text("[SIZE=1", 1'b1);
    quiesce();
  endtask

  task automatic test_incomplete_tag();
    send_text("[/co", 1'b1);
    quiesce();
  endtask

  task automatic test_disable_mid_string();
    send_text("[col", 1'b0);
    quiesce();
    set_strip(1'b0);
    send_text("x[b]", 1'b1);
    quiesce();
    set_strip(1'b1);
  endtask

  task automatic test_random_phase(input int gap, input int stall, input bit en,
                                   input int items);
    gap_pct = gap;
    stall_pct = stall;
    set_strip(en);
    counted_chars = 0;
    while (counted_chars < items) begin
      send_random_piece();
      if ($urandom_range(39) == 0) quiesce();
    end
    quiesce();
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.in_char <= '0;
    in_chan.in_last <= 1'b0;
    strip_on   = 1'b1;
    held_count = 0;
    skip_mode  = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_extremes();
    test_rescan_and_wide();
    test_unclosed_opener();
    test_incomplete_tag();
    test_disable_mid_string();
    test_random_phase(0, 0, 1'b1, 110);
    test_random_phase(86, 0, 1'b1, 110);
    test_random_phase(0, 86, 1'b1, 110);
    test_random_phase(20, 20, 1'b1, 110);
    test_random_phase(20, 20, 1'b0, 60);
    test_random_phase(0, 0, 1'b1, 20);

    if (mismatch_count == 0) begin
      $display("markup_tag_stripper_core: match");
    end else begin
      $display("markup_tag_stripper_core: mismatch");
    end
    $finish;
  end

endmodule
